/* rtl/wbps_pkg.sv */
`timescale 1ns / 1ps

package wbps_pkg;

    // sizes
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int HISTORY_DEPTH     = 16;
    localparam int HIST_IDX_BITS     = $clog2(HISTORY_DEPTH);
    localparam int OFFSET_BITS       = 32;
    localparam int MATCH_OFFSET_BITS = 32;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int LEN_BITS          = 5;
    localparam int PATTERN_REG_BYTES = 2 * CFG_DATA_BITS / 8;

    // pattern byte that matches anything
    localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOWER  = 2'd0,
        CFG_PATTERN_UPPER  = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // pattern as seen by the window compare: entry j lines up with the
    // j-th newest byte of the history
    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][7:0] aligned;
        logic [HISTORY_DEPTH-1:0]      care;
        logic [LEN_BITS-1:0]           length;
    } cfg_t;

endpackage

/* rtl/wbps_cfg_regs.sv */
`timescale 1ns / 1ps

module wbps_cfg_regs
    import wbps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    logic [CFG_DATA_BITS-1:0] pattern_lower_reg;
    logic [CFG_DATA_BITS-1:0] pattern_upper_reg;
    logic [LEN_BITS-1:0]      length_reg;
    logic [LEN_BITS-1:0]      length_next;
    logic [LEN_BITS-1:0]      length_raw;

    // length is stored already clamped to the usable range
    always_comb
    begin
        length_raw = cfg_data[LEN_BITS-1:0];
        if (length_raw == '0)
            length_next = LEN_BITS'(1);
        else if (length_raw > LEN_BITS'(MAX_PATTERN_BYTES))
            length_next = LEN_BITS'(MAX_PATTERN_BYTES);
        else
            length_next = length_raw;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_lower_reg <= '0;
            pattern_upper_reg <= '0;
            length_reg        <= LEN_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOWER:  pattern_lower_reg <= cfg_data;
                CFG_PATTERN_UPPER:  pattern_upper_reg <= cfg_data;
                CFG_PATTERN_LENGTH: length_reg        <= length_next;
                default: ;
            endcase
        end
    end

    // line the pattern up against the history, last pattern byte on newest
    always_comb
    begin
        logic [PATTERN_REG_BYTES-1:0][7:0] pattern;
        logic [LEN_BITS-1:0]               pos;
        pattern = {pattern_upper_reg, pattern_lower_reg};
        cfg.length = length_reg;
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            pos = length_reg - LEN_BITS'(j) - LEN_BITS'(1);
            cfg.aligned[j] = pattern[pos[HIST_IDX_BITS-1:0]];
            cfg.care[j]    = (LEN_BITS'(j) < length_reg) &&
                             (pattern[pos[HIST_IDX_BITS-1:0]] != WILDCARD_BYTE);
        end
    end

endmodule

/* rtl/wbps_window.sv */
`timescale 1ns / 1ps

module wbps_window
    import wbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear_en,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output logic       hit
);

    logic [HISTORY_DEPTH-1:0][7:0] hist_reg;
    logic [HISTORY_DEPTH-1:0][7:0] hist_next;
    logic [HISTORY_DEPTH-1:0][7:0] window;
    logic [HISTORY_DEPTH-1:0]      byte_ok;

    // window as it stands once the incoming byte is shifted in
    always_comb
    begin
        window[0] = data_byte;
        for (int j = 1; j < HISTORY_DEPTH; j++)
            window[j] = hist_reg[j-1];
    end

    // parallel compare of every window position
    always_comb
    begin
        for (int j = 0; j < HISTORY_DEPTH; j++)
            byte_ok[j] = !cfg.care[j] || (window[j] == cfg.aligned[j]);
        hit = &byte_ok;
    end

    // history update
    always_comb
    begin
        if (clear_en)
            hist_next = '0;
        else if (shift_en)
            hist_next = window;
        else
            hist_next = hist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else
            hist_reg <= hist_next;
    end

endmodule

/* rtl/wildcard_byte_pattern_scanner_top.sv */
`timescale 1ns / 1ps

// Byte signature scanner. Bytes of a region stream in on the input channel,
// one beat per byte, with end_of_region set on the last one. The last
// pattern_length bytes are compared in parallel against the configured
// signature (pattern byte 0x2A matches any byte) on every byte, so
// overlapping candidates are found. The first match of a region gives one
// result beat with found set and the offset of the match start; later bytes
// of that region give nothing and its end marker rearms the scanner. A region
// that ends without a match gives one beat with found clear and offset zero.
// One byte is taken every clock cycle; the result appears in the cycle after the
// byte that causes it, held in a single output register, and the input only
// stalls while that register is full and not being taken. The region byte
// count saturates at all ones, and a match past that point reports all ones.
// Write the configuration only while the scanner is idle.
module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_region,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [MATCH_OFFSET_BITS-1:0] match_offset
);

    localparam logic [OFFSET_BITS-1:0] COUNT_LIMIT = '1;

    cfg_t                         cfg;
    logic                         hit;
    logic                         in_fire;
    logic                         shift_en;
    logic                         clear_en;
    logic                         emit;
    logic                         emit_found;
    logic                         matched;
    logic [OFFSET_BITS-1:0]       count_inc;
    logic [OFFSET_BITS-1:0]       offset;

    logic [OFFSET_BITS-1:0]       count_reg;
    logic [OFFSET_BITS-1:0]       count_next;
    logic                         reported_reg;
    logic                         reported_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic [MATCH_OFFSET_BITS-1:0] match_offset_reg;

    wbps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .clear_en  (clear_en),
        .data_byte (data_byte),
        .cfg       (cfg),
        .hit       (hit)
    );

    // input handshake: free whenever the output register is empty or is taken this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // saturating byte count and match offset
    always_comb
    begin
        count_inc = (count_reg == COUNT_LIMIT) ? count_reg
                                               : count_reg + OFFSET_BITS'(1);
        matched   = hit && (count_inc >= OFFSET_BITS'(cfg.length));
        offset    = (count_inc == COUNT_LIMIT) ? COUNT_LIMIT
                                               : count_inc - OFFSET_BITS'(cfg.length);
    end

    // per-beat control
    always_comb
    begin
        shift_en      = 1'b0;
        clear_en      = 1'b0;
        emit          = 1'b0;
        emit_found    = 1'b0;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (in_fire)
        begin
            if (reported_reg)
            begin
                // match already given: wait for the end marker
                if (end_of_region)
                begin
                    clear_en      = 1'b1;
                    count_next    = '0;
                    reported_next = 1'b0;
                end
            end
            else
            begin
                shift_en   = 1'b1;
                count_next = count_inc;
                if (matched)
                begin
                    emit          = 1'b1;
                    emit_found    = 1'b1;
                    reported_next = 1'b1;
                end
                else if (end_of_region)
                begin
                    emit = 1'b1;
                end
                if (end_of_region)
                begin
                    clear_en      = 1'b1;
                    count_next    = '0;
                    reported_next = 1'b0;
                end
            end
        end
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || emit;

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_reg        <= emit_found;
            match_offset_reg <= emit_found ? MATCH_OFFSET_BITS'(offset) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = match_offset_reg;

endmodule

/* rtl/wbps_checker.sv */
`timescale 1ns / 1ps

module wbps_checker
    import wbps_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         found,
    input logic [MATCH_OFFSET_BITS-1:0] match_offset
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
        else $error("result beat changed while stalled");

    // a not-found beat carries a zero offset
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("not-found beat with non-zero offset");

    // a new result only follows an accepted input beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result beat without an input beat");

    // input is never held off while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import wbps_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic                         found;
        logic [MATCH_OFFSET_BITS-1:0] offset;
    } scan_result_t;

    typedef logic [7:0] region_t [$];

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [7:0]                   data_byte = '0;
    logic                         end_of_region = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         found;
    logic [MATCH_OFFSET_BITS-1:0] match_offset;

    // scanner state as the checker tracks it
    logic [CFG_DATA_BITS-1:0]     sig_lo = '0;
    logic [CFG_DATA_BITS-1:0]     sig_hi = '0;
    logic [LEN_BITS-1:0]          sig_len = LEN_BITS'(1);
    logic [7:0]                   hist [HISTORY_DEPTH];
    logic [OFFSET_BITS-1:0]       region_count = '0;
    bit                           hit_latched = 1'b0;

    scan_result_t                 pending_hits [$];
    int                           mismatches = 0;
    int                           bytes_sent = 0;
    int                           stuck_cycles = 0;
    bit                           sender_idle_on = 1'b1;
    bit                           receiver_idle_on = 1'b1;
    int                           hold_request = 0;
    int                           hold_left = 0;

    wildcard_byte_pattern_scanner_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_region (end_of_region),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_offset  (match_offset)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // signature byte k out of the two pattern words
    function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input int k);
        return (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
    endfunction

    // lengths outside 1..16 are folded into range
    function automatic int clamp_len(input logic [LEN_BITS-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_PATTERN_BYTES)
            return MAX_PATTERN_BYTES;
        return int'(n);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist[i] = 8'h00;
        region_count = '0;
        hit_latched = 1'b0;
    endfunction

    function automatic bit window_hit(input int len);
        logic [7:0] p;
        for (int k = 0; k < len; k++)
        begin
            p = pick_byte(sig_lo, sig_hi, k);
            if (p != WILDCARD_BYTE && p != hist[len - 1 - k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the tracked scanner by one byte; returns 1 when a result is due
    function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                     output scan_result_t res);
        int len;
        len = clamp_len(sig_len);
        res = '0;
        if (hit_latched)
        begin
            if (last)
                clear_history();
            return 1'b0;
        end
        for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            hist[i] = hist[i - 1];
        hist[0] = b;
        if (region_count != '1)
            region_count = region_count + OFFSET_BITS'(1);
        if (region_count >= OFFSET_BITS'(len) && window_hit(len))
        begin
            res.found = 1'b1;
            res.offset = (region_count == '1) ? '1
                                              : MATCH_OFFSET_BITS'(region_count - len);
            if (last)
                clear_history();
            else
                hit_latched = 1'b1;
            return 1'b1;
        end
        if (last)
        begin
            clear_history();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: mismatch on %s, got %0h want %0h", $time, what, got, want);
    endtask

    // track configuration, check result beats, predict from input beats
    always @(posedge clk)
    begin : scoreboard
        scan_result_t got_res;
        scan_result_t want_res;
        scan_result_t new_res;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN_LOWER:  sig_lo = cfg_data;
                    CFG_PATTERN_UPPER:  sig_hi = cfg_data;
                    CFG_PATTERN_LENGTH: sig_len = cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got_res.found = found;
                got_res.offset = match_offset;
                if (pending_hits.size() == 0)
                    flag_mismatch("result beat with nothing pending", 32'(found), 32'h0);
                else
                begin
                    want_res = pending_hits.pop_front();
                    if (got_res.found !== want_res.found)
                        flag_mismatch("found", 32'(got_res.found), 32'(want_res.found));
                    if (got_res.offset !== want_res.offset)
                        flag_mismatch("match_offset", got_res.offset, want_res.offset);
                end
            end
            if (in_valid && in_ready)
            begin
                if (scan_byte(data_byte, end_of_region, new_res))
                    pending_hits.push_back(new_res);
            end
        end
    end

    // watchdog on beats in either direction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls plus requested hold-offs
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(receiver_idle_on && $urandom_range(0, 99) < 10);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (sender_idle_on && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_region <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_region(input region_t bytes, input bit closed = 1'b1);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], closed && (i == bytes.size() - 1));
    endtask

    // stop sending and wait for every pending result, plus the pipeline stage
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [LEN_BITS-1:0] len);
        settle();
        write_reg(CFG_PATTERN_LOWER, lo);
        write_reg(CFG_PATTERN_UPPER, hi);
        // upper bits of the length word carry junk, only five bits count
        write_reg(CFG_PATTERN_LENGTH, {32'($urandom), 27'($urandom), len});
    endtask

    // reset pattern is a single zero byte
    task automatic test_reset_pattern();
        send_region('{8'h00, 8'h55, 8'h77});
        send_region('{8'hFF});
    endtask

    // region shorter than the signature, wildcard, match on the last byte
    task automatic test_short_region();
        load_pattern(64'h0000_0000_0000_2A00 | 64'h0, 64'h0, 5'd3);
        send_region('{8'h00, 8'h00});
        send_region('{8'h00, 8'h77, 8'h00});
        send_region('{8'h00});
    endtask

    // overlapping candidate, and the end marker after a match
    task automatic test_overlap();
        load_pattern(64'h0000_0000_00AB_AAAA, 64'h0, 5'd3);
        send_region('{8'hAA, 8'hAA, 8'hAA, 8'hAB, 8'h2A, 8'hAB});
    endtask

    // length zero behaves as one
    task automatic test_zero_length();
        load_pattern(64'h0000_0000_0000_00FF, '1, 5'd0);
        send_region('{8'h10, 8'hFF});
    endtask

    // new signature mid-region keeps the history
    task automatic test_config_mid_region();
        load_pattern(64'h0000_0000_0000_3412, 64'h0, 5'd2);
        send_region('{8'h12}, 1'b0);
        settle();
        write_reg(CFG_PATTERN_LOWER, 64'h0000_0000_0000_5612);
        send_region('{8'h56, 8'h00});
    endtask

    // receiver holds off while short regions keep coming
    task automatic test_backpressure();
        region_t r;
        load_pattern(64'h0000_0000_0000_005A, 64'h0, 5'd1);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
        begin
            r.delete();
            for (int j = $urandom_range(1, 3); j > 0; j--)
                r.push_back($urandom_range(0, 1) ? 8'h5A : 8'($urandom));
            send_region(r);
        end
        settle();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
    endtask

    // random signatures with regions that mostly carry them
    task automatic test_random_scan();
        int          lens [9] = '{1, 16, 0, 31, 17, 2, 8, 5, 12};
        logic [63:0] lo;
        logic [63:0] hi;
        int          eff;
        int          kind;
        int          n;
        int          pos;
        int          phase_start;
        bit          paused;
        logic [7:0]  b;
        region_t     r;
        for (int p = 0; p < 9; p++)
        begin
            lo = (p == 1) ? '1 : {$urandom, $urandom};
            hi = (p == 1) ? '1 : {$urandom, $urandom};
            if (p == 2)
                hi = '0;
            for (int k = 0; k < 16; k++)
                if (p != 1 && $urandom_range(0, 3) == 0)
                begin
                    if (k < 8)
                        lo[k*8 +: 8] = WILDCARD_BYTE;
                    else
                        hi[(k-8)*8 +: 8] = WILDCARD_BYTE;
                end
            eff = clamp_len(LEN_BITS'(lens[p]));
            load_pattern(lo, hi, LEN_BITS'(lens[p]));
            // one phase runs with no idling on either side
            sender_idle_on = (p != 4);
            receiver_idle_on = (p != 4);
            phase_start = bytes_sent;
            paused = 1'b0;
            while (bytes_sent - phase_start < 200)
            begin
                kind = $urandom_range(0, 9);
                n = (kind == 8) ? $urandom_range(1, 60) : $urandom_range(1, 2 * eff + 6);
                r.delete();
                for (int i = 0; i < n; i++)
                begin
                    if (kind == 9 || (kind <= 6 && $urandom_range(0, 1)))
                        r.push_back(pick_byte(lo, hi, $urandom_range(0, eff - 1)));
                    else
                        r.push_back(8'($urandom));
                end
                // plant the signature, wildcards filled at random
                if (kind <= 6 && n >= eff)
                begin
                    pos = $urandom_range(0, n - eff);
                    for (int k = 0; k < eff; k++)
                    begin
                        b = pick_byte(lo, hi, k);
                        r[pos + k] = (b == WILDCARD_BYTE) ? 8'($urandom) : b;
                    end
                end
                send_region(r);
                if (!paused && bytes_sent - phase_start >= 100)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
    endtask

    initial
    begin
        clear_history();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_pattern();
        test_short_region();
        test_overlap();
        test_zero_length();
        test_config_mid_region();
        test_backpressure();
        test_random_scan();
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
